/* src/sil_pkg.sv */
// Package for the sorted insert list: sizes, operation and status codes,
// and the packed request, response and cell control types.
// No dependencies; every other file of the block uses it by scoped names.
package sil_pkg;

   localparam int DEPTH = 64;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 6;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int VAL_W = 32;
   localparam int OUT_CNT_W = 7;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   localparam logic [1:0] MODE_APPEND = 2'd0;
   localparam logic [1:0] MODE_ASC    = 2'd1;
   localparam logic [1:0] MODE_DESC   = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]              kind;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] read_value;
      logic [1:0]              status;
      logic [OUT_CNT_W-1:0]    count;
   } rsp_type;

   // Broadcast from the top level to every cell of the row.
   typedef struct packed {
      logic                    ins_en;
      logic                    rem_en;
      logic                    rd_en;
      logic [1:0]              mode;
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        pos;
   } cell_ctrl_type;

endpackage

/* src/sil_cell.sv */
// One cell of the sorted insert list: holds a single entry, compares it with
// the incoming value and shifts toward either neighbor. Depends on sil_pkg.
module sil_cell (
   input  logic                             clock,
   input  sil_pkg::cell_ctrl_type           ctrl,
   input  logic [sil_pkg::CNT_W-1:0]        idx,
   input  logic [sil_pkg::CNT_W-1:0]        count,
   input  logic signed [sil_pkg::VAL_W-1:0] left_value,
   input  logic signed [sil_pkg::VAL_W-1:0] right_value,
   input  logic                             found_in,
   output logic signed [sil_pkg::VAL_W-1:0] value_out,
   output logic                             found_out,
   output logic signed [sil_pkg::VAL_W-1:0] rd_data
);

   logic signed [sil_pkg::VAL_W-1:0] entry_ff;
   logic signed [sil_pkg::VAL_W-1:0] entry_in;
   logic                             entry_we;
   logic                             valid;
   logic                             goes_ahead;
   logic                             last_valid;

   assign valid = (idx < count);
   // True for every occupied cell but the last occupied one.
   assign last_valid = (({1'b0, idx} + 1'b1) < {1'b0, count});

   always_comb begin
      case (ctrl.mode)
         sil_pkg::MODE_ASC:  goes_ahead = valid && (entry_ff > ctrl.value);
         sil_pkg::MODE_DESC: goes_ahead = valid && (ctrl.value > entry_ff);
         default:            goes_ahead = 1'b0;
      endcase
   end

   // The first cell that wants the new value ahead of itself takes it; all
   // later cells up to the new tail take their left neighbor's entry.
   assign found_out = found_in | goes_ahead;

   always_comb begin
      entry_we = 1'b0;
      entry_in = entry_ff;
      if (ctrl.ins_en) begin
         if (found_in && (idx <= count)) begin
            entry_we = 1'b1;
            entry_in = left_value;
         end else if (!found_in && (goes_ahead || (idx == count))) begin
            entry_we = 1'b1;
            entry_in = ctrl.value;
         end
      end else if (ctrl.rem_en && (idx >= ctrl.pos) && last_valid) begin
         entry_we = 1'b1;
         entry_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_ff <= entry_in;
      end
   end

   assign value_out = entry_ff;
   assign rd_data   = (ctrl.rd_en && (idx == ctrl.pos)) ? entry_ff : '0;

endmodule

/* src/sorted_insert_list_top.sv */
// Top level of the sorted insert list: handshakes, entry count, mode register
// and the row of sil_cell instances. Depends on sil_pkg and sil_cell.
//
//   Channel   Direction  Ports                               Carries
//   req       in         req_valid, req_ready, req_data      add, read or remove item
//   rsp       out        rsp_valid, rsp_ready, rsp_data      value, status, count
//   csr       in         csr_wr_en, csr_wr_data              order mode register
//
// Every cell compares its entry with the incoming value in parallel and
// shifts at the same edge, so one transfer per cycle is sustained while
// responses are taken. The result sits in an output register; a new
// request transfer is taken whenever that register is empty or being drained.
// Reset is synchronous and clears the entry count, the mode and the output
// valid; the cell contents are left as they are since no cell past the count
// is ever read. A stalled response holds off further request transfers.
module sorted_insert_list_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sil_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sil_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data
);

   localparam int DEPTH = sil_pkg::DEPTH;
   localparam int CNT_W = sil_pkg::CNT_W;
   localparam int VAL_W = sil_pkg::VAL_W;
   localparam int CMP_W = sil_pkg::CMP_W;

   logic [1:0]       mode_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   sil_pkg::rsp_type rsp_data_ff;
   sil_pkg::rsp_type rsp_data_in;

   logic             accept;
   logic             full;
   logic             pos_ok;
   sil_pkg::cell_ctrl_type ctrl;

   logic signed [VAL_W-1:0] cell_value [DEPTH];
   logic signed [VAL_W-1:0] cell_rd    [DEPTH];
   logic                    cell_found [DEPTH];
   logic signed [VAL_W-1:0] read_data;

   // A new request may enter when the response register is free or draining.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign full   = (count_ff == CNT_W'(DEPTH));
   // Position is valid only below the current count; compared at a common width.
   assign pos_ok = (CMP_W'(req_data.position) < CMP_W'(count_ff));

   always_comb begin
      ctrl.ins_en = 1'b0;
      ctrl.rem_en = 1'b0;
      ctrl.rd_en  = 1'b0;
      ctrl.mode   = mode_ff;
      ctrl.value  = req_data.item_value;
      ctrl.pos    = CMP_W'(req_data.position) >= CMP_W'(DEPTH) ? '0
                    : CNT_W'(CMP_W'(req_data.position));
      count_in    = count_ff;
      rsp_data_in.read_value = read_data;
      rsp_data_in.status     = sil_pkg::STATUS_OK;
      unique case (req_data.kind)
         sil_pkg::KIND_ADD: begin
            if (full) begin
               rsp_data_in.status = sil_pkg::STATUS_FULL;
            end else begin
               ctrl.ins_en = accept;
               count_in    = count_ff + 1'b1;
            end
         end
         sil_pkg::KIND_READ: begin
            if (pos_ok) begin
               ctrl.rd_en = 1'b1;
            end else begin
               rsp_data_in.status = sil_pkg::STATUS_NOT_FOUND;
            end
         end
         sil_pkg::KIND_REMOVE: begin
            if (pos_ok) begin
               ctrl.rd_en  = 1'b1;
               ctrl.rem_en = accept;
               count_in    = count_ff - 1'b1;
            end else begin
               rsp_data_in.status = sil_pkg::STATUS_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
      rsp_data_in.count = sil_pkg::OUT_CNT_W'(count_in);
   end

   // Row of cells. The insert search ripples a found flag from cell 0 upward,
   // and entries shift one place right on insert or left on remove.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VAL_W-1:0] left_value;
      logic signed [VAL_W-1:0] right_value;
      logic                    found_in;

      if (i == 0) begin : g_first
         assign left_value = '0;
         assign found_in   = 1'b0;
      end else begin : g_mid
         assign left_value = cell_value[i-1];
         assign found_in   = cell_found[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      sil_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .idx         (CNT_W'(i)),
         .count       (count_ff),
         .left_value  (left_value),
         .right_value (right_value),
         .found_in    (found_in),
         .value_out   (cell_value[i]),
         .found_out   (cell_found[i]),
         .rd_data     (cell_rd[i])
      );
   end

   // At most one cell drives a nonzero read word, so the words are ORed.
   always_comb begin
      read_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_data = read_data | cell_rd[i];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= sil_pkg::MODE_APPEND;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
